// ----- design/mma_pkg.sv -----
// shared types and constants of the multichannel moving average block
// no dependencies; imported by every module of the block
package mma_pkg;

    localparam int NUM_CH          = 4;
    localparam int CH_W            = 2;
    localparam int WIN_W           = 7;
    localparam int SAMPLE_W        = 12;
    localparam int AVG_W           = 12;
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd16;

    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [AVG_W-1:0] average_ch0;
        logic [AVG_W-1:0] average_ch1;
        logic [AVG_W-1:0] average_ch2;
        logic [AVG_W-1:0] average_ch3;
    } t_out_item;

endpackage

// ----- design/mma_ring.sv -----
// sample store: one ring region per channel, one write and one registered read port
// depends on mma_pkg
module mma_ring #(
    parameter int PW          = 6,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [PW+1:0]          i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic [PW+1:0]          i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);
    import mma_pkg::*;

    localparam int DEPTH = NUM_CH << PW;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/mma_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on mma_pkg
module mma_div #(
    parameter int DW = 19,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    import mma_pkg::*;

    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [DW-1:0]    r_q;
    logic [VW:0]      shifted;
    logic             fits;
    logic [VW:0]      diff;

    always_comb begin
        shifted = {r_rem, r_q[DW-1]};
        fits    = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[VW-1:0] : shifted[VW-1:0];
            r_q   <= {r_q[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- design/multichannel_moving_average_top.sv -----
// four-channel boxcar moving average: sequencer, ring state and result register
// depends on mma_pkg, mma_ring, mma_div
//
//  channel | handshake                 | payload
//  in      | i_in_valid / o_in_ready   | i_in_item  (opcode, channel, sample)
//  out     | o_out_valid / i_out_ready | o_out_item (average_ch0..average_ch3)
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data (window per channel)
//
// a store item is written straight into its channel's ring; a report walks the
// channels one after the other, summing the stored samples of each through the
// registered read port, then dividing in the shared bit-serial divider
// reset is synchronous; no clearing pass, the store holds garbage until written
// o_in_ready is low during a report, while a finished report waits on i_out_ready
// and while a window write is offered; o_cfg_ready is low during a report
module multichannel_moving_average_top #(
    parameter int MAX_WINDOW  = mma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  mma_pkg::t_in_item       i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output mma_pkg::t_out_item      o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [mma_pkg::CH_W-1:0]  i_cfg_index,
    input  logic [mma_pkg::WIN_W-1:0] i_cfg_data
);
    import mma_pkg::*;

    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int PW  = $clog2(MAX_WINDOW);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int EW  = (CW > WIN_W) ? CW : WIN_W;
    localparam int SXW = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int QXW = (SW > AVG_W) ? SW : AVG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state;
    logic [WIN_W-1:0] r_win  [NUM_CH];
    logic [PW-1:0]    r_pos  [NUM_CH];
    logic [CW-1:0]    r_fill [NUM_CH];
    logic [CH_W-1:0]  r_ch;
    logic [CW-1:0]    r_idx;
    logic             r_rd_pend;
    logic [SW-1:0]    r_acc;
    logic [AVG_W-1:0] r_avg  [NUM_CH];
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_acc;
    logic             store_acc;
    logic             report_acc;
    logic             cfg_acc;
    logic [CH_W-1:0]  sch;
    logic [EW-1:0]    w_ext;
    logic [CW-1:0]    win;
    logic [PW-1:0]    wpos;
    logic [CW-1:0]    pos_inc;
    logic [PW-1:0]    n_pos;
    logic [SXW-1:0]   smp_ext;
    logic [CW-1:0]    cur_n;
    logic             issue;
    logic             sum_end;
    logic             div_start;
    logic             div_done;
    logic [SW-1:0]    quotient;
    logic [QXW-1:0]   q_ext;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic             out_load;

    // a window write goes first, so a store never meets a clear in one cycle
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign store_acc   = in_acc && (i_in_item.opcode == OP_STORE);
    assign report_acc  = in_acc && (i_in_item.opcode == OP_REPORT);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // effective window and next write position of the addressed channel
    always_comb begin
        sch   = i_in_item.channel;
        w_ext = EW'(r_win[sch]);
        if (w_ext == '0) begin
            win = CW'(1);
        end else if (w_ext > EW'(MAX_WINDOW)) begin
            win = CW'(MAX_WINDOW);
        end else begin
            win = CW'(w_ext);
        end
        wpos    = (CW'(r_pos[sch]) >= win) ? '0 : r_pos[sch];
        pos_inc = CW'(wpos) + CW'(1);
        n_pos   = (pos_inc >= win) ? '0 : pos_inc[PW-1:0];
        smp_ext = SXW'(i_in_item.sample);
    end

    always_comb begin
        cur_n     = r_fill[r_ch];
        issue     = (r_state == S_SUM) && (r_idx != cur_n);
        sum_end   = (r_state == S_SUM) && (r_idx == cur_n) && !r_rd_pend;
        div_start = sum_end;
        q_ext     = QXW'(quotient);
        out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    mma_ring #(
        .PW          (PW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (store_acc),
        .i_waddr ({sch, wpos}),
        .i_wdata (smp_ext[SAMPLE_BITS-1:0]),
        .i_raddr ({r_ch, r_idx[PW-1:0]}),
        .o_rdata (rd_data)
    );

    mma_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (cur_n),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // window registers, ring positions and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_win[c]  <= WIN_RESET;
                r_pos[c]  <= '0;
                r_fill[c] <= '0;
            end
        end else if (cfg_acc) begin
            r_win[i_cfg_index]  <= i_cfg_data;
            r_pos[i_cfg_index]  <= '0;
            r_fill[i_cfg_index] <= '0;
        end else if (store_acc) begin
            r_pos[sch] <= n_pos;
            if (r_fill[sch] < win) begin
                r_fill[sch] <= r_fill[sch] + CW'(1);
            end
        end
    end

    // report sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= issue;
            if (o_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (report_acc) begin
                        r_state <= S_SUM;
                        r_ch    <= '0;
                        r_idx   <= '0;
                    end
                end
                S_SUM: begin
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (sum_end) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_idx <= '0;
                        if (r_ch == CH_W'(NUM_CH - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ch    <= r_ch + CH_W'(1);
                            r_state <= S_SUM;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // accumulator and per-channel averages
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) || ((r_state == S_DIV) && div_done)) begin
            r_acc <= '0;
        end else if (r_rd_pend) begin
            r_acc <= r_acc + SW'(rd_data);
        end
        if ((r_state == S_DIV) && div_done) begin
            r_avg[r_ch] <= (cur_n == '0) ? '0 : q_ext[AVG_W-1:0];
        end
        if (out_load) begin
            r_out.average_ch0 <= r_avg[0];
            r_out.average_ch1 <= r_avg[1];
            r_out.average_ch2 <= r_avg[2];
            r_out.average_ch3 <= r_avg[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- tb/sv/multichannel_moving_average_top_tb.sv -----
// self-checking bench for the four-channel boxcar moving average block
// needs mma_pkg and multichannel_moving_average_top; runs stand-alone
module multichannel_moving_average_top_tb;
    import mma_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int DRAIN_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CH_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0] cfg_data = '0;

    // channel state mirrored from the block
    logic [WIN_W-1:0] window_reg [NUM_CH];
    logic [SAMPLE_W-1:0] ring [NUM_CH][RING_DEPTH];
    int wr_pos [NUM_CH];
    int fill [NUM_CH];

    t_in_item adc_items [$];
    t_out_item expected_averages [$];

    int items_sent = 0;
    int items_taken = 0;
    int reports_seen = 0;
    int mismatches = 0;
    int send_idle_pct = 29;
    int recv_idle_pct = 66;
    int stall_left = 0;
    bit stall_done = 1'b0;

    multichannel_moving_average_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            window_reg[ch] = WIN_RESET;
            wr_pos[ch] = 0;
            fill[ch] = 0;
        end
    end

    function automatic int eff_window(int ch);
        if (window_reg[ch] == 0) return 1;
        if (window_reg[ch] > RING_DEPTH) return RING_DEPTH;
        return int'(window_reg[ch]);
    endfunction

    function automatic t_out_item current_averages();
        logic [NUM_CH*AVG_W-1:0] flat;
        int sum;
        flat = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum = 0;
            for (int i = 0; i < fill[ch]; i++) sum += ring[ch][i];
            if (fill[ch] != 0)
                flat[(NUM_CH-1-ch)*AVG_W +: AVG_W] = AVG_W'(sum / fill[ch]);
        end
        return t_out_item'(flat);
    endfunction

    function automatic void apply_item(t_in_item it);
        int ch;
        int win;
        if (it.opcode == OP_REPORT) begin
            expected_averages.push_back(current_averages());
        end else begin
            ch = int'(it.channel);
            win = eff_window(ch);
            if (wr_pos[ch] >= win) wr_pos[ch] = 0;
            ring[ch][wr_pos[ch]] = it.sample;
            wr_pos[ch]++;
            if (wr_pos[ch] >= win) wr_pos[ch] = 0;
            if (fill[ch] < win) fill[ch]++;
        end
    endfunction

    function automatic logic [AVG_W-1:0] avg_field(t_out_item r, int ch);
        logic [NUM_CH*AVG_W-1:0] flat;
        flat = r;
        return flat[(NUM_CH-1-ch)*AVG_W +: AVG_W];
    endfunction

    // driver: a new item only once the previous one has been taken
    always @(negedge i_clk) begin
        if (i_rst_n && items_taken == items_sent) begin
            if (adc_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_item <= adc_items.pop_front();
                in_valid <= 1'b1;
                items_sent <= items_sent + 1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off so the block backs up into its input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && reports_seen >= 12) begin
            stall_done <= 1'b1;
            stall_left <= 3000;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) begin
                window_reg[cfg_index] = cfg_data;
                wr_pos[cfg_index] = 0;
                fill[cfg_index] = 0;
            end
            if (in_valid && in_ready) begin
                items_taken++;
                apply_item(in_item);
            end
            if (out_valid && out_ready) begin
                reports_seen++;
                if (expected_averages.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result %h", $time, out_item);
                end else begin
                    want = expected_averages.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (avg_field(out_item, ch) !== avg_field(want, ch)) begin
                            mismatches++;
                            $display("%0t: average_ch%0d expected %0d actual %0d",
                                     $time, ch, avg_field(want, ch),
                                     avg_field(out_item, ch));
                        end
                    end
                end
            end
        end
    end

    task automatic add_store(int ch, int s);
        t_in_item it;
        it.opcode = OP_STORE;
        it.channel = CH_W'(ch);
        it.sample = SAMPLE_W'(s);
        adc_items.push_back(it);
    endtask

    task automatic add_report(int ch, int s);
        t_in_item it;
        it.opcode = OP_REPORT;
        it.channel = CH_W'(ch);
        it.sample = SAMPLE_W'(s);
        adc_items.push_back(it);
    endtask

    // all items taken, all reports back, then room for a trailing store
    task automatic drain();
        while (adc_items.size() != 0 || items_taken != items_sent) @(posedge i_clk);
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_windows(logic [WIN_W-1:0] wins [NUM_CH]);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            @(negedge i_clk);
            cfg_valid = 1'b1;
            cfg_index = CH_W'(ch);
            cfg_data = wins[ch];
            @(posedge i_clk);
            while (!cfg_ready) @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WIN_W'(RING_DEPTH);
            2: return '1;
            3: return WIN_W'($urandom_range(RING_DEPTH + 1, 127));
            default: return WIN_W'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return (1 << SAMPLE_W) - 1;
            default: return $urandom_range(0, (1 << SAMPLE_W) - 1);
        endcase
    endfunction

    initial begin
        logic [WIN_W-1:0] wins [NUM_CH];
        int focus;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset windows: empty report with ignored fields all ones, then extremes
        add_report(3, 4095);
        add_store(0, 4095);
        add_store(0, 4095);
        add_store(1, 0);
        add_store(2, 12'hAAA);
        add_store(3, 12'h555);
        add_report(0, 0);
        drain();

        // window of one, full window, zero and oversize windows
        wins = '{7'd1, 7'd64, 7'd0, 7'd127};
        write_windows(wins);
        add_report(1, 12'h123);
        add_store(0, 100);
        add_store(0, 4095);
        add_store(2, 7);
        add_store(2, 9);
        add_store(1, 4095);
        add_store(1, 1);
        add_store(3, 3);
        add_store(3, 4);
        add_report(2, 12'hFFF);
        add_store(0, 0);
        add_report(0, 0);
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 66;
                recv_idle_pct = 29;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int ch = 0; ch < NUM_CH; ch++) wins[ch] = pick_window();
            write_windows(wins);
            // one channel gets most samples so its ring wraps
            focus = seg % NUM_CH;
            for (int n = 0; n < 180; n++) begin
                if ($urandom_range(0, 5) == 0)
                    add_report($urandom_range(0, 3), $urandom_range(0, 4095));
                else if ($urandom_range(0, 3) != 0)
                    add_store(focus, pick_sample());
                else
                    add_store($urandom_range(0, 3), pick_sample());
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
